FILE: design/dlla_pkg.sv
// Shared definitions for the performance-level lock and limit arbiter.
// Holds field widths, opcodes, register indexes and default sizes.
// Depends on nothing.
package dlla_pkg;

	localparam int DLLA_NUM_REQ    = 16;
	localparam int DLLA_NUM_LEVELS = 6;

	localparam int LVL_W     = 3;
	localparam int REQ_W     = 4;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 3;

	typedef logic [LVL_W-1:0] level_t;
	typedef logic [OP_W-1:0]  opcode_t;

	localparam opcode_t OP_QUERY     = 3'd0;
	localparam opcode_t OP_LOCK      = 3'd1;
	localparam opcode_t OP_LOCK_REL  = 3'd2;
	localparam opcode_t OP_LIMIT     = 3'd3;
	localparam opcode_t OP_LIMIT_REL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHEST = 1'd1;

endpackage

FILE: design/dvfs_level_lock_limit_arbiter.sv
// Top level of the performance-level lock and limit arbiter.
// Uses dlla_pkg; per-requester lock and limit values live in two small memories.
//
// Each input word yields one result word. Queries, locks, limits, dropped
// operations and releases from an unknown requester are answered in the cycle
// after acceptance. On a valid release the aggregate is rebuilt by reading the
// value memory one entry per cycle through its single read port, and only held
// entries count. One word is in flight at a time; the next is taken once the
// result register is free or being drained. Level 0 is the fastest; lock_level
// is the minimum over held locks (slowest level on reset) and limit_level the
// maximum over held limits, starting from highest_supported_level after a
// release. The user must write configuration only while idle; it is not enforced.
module dvfs_level_lock_limit_arbiter
	import dlla_pkg::*;
#(
	parameter int NUM_REQUESTERS = DLLA_NUM_REQ,
	parameter int NUM_LEVELS     = DLLA_NUM_LEVELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// requester [3:0], level [6:4], zero [7]
	input  logic [7:0]           s_axis_tdata,
	// opcode [2:0]
	input  logic [OP_W-1:0]      s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// clamped_level [2:0], lock_level [5:3], limit_level [8:6],
	// already_held [9], ignored_disabled [10], zero [15:11]
	output logic [15:0]          m_axis_tdata
);

	localparam int IDX_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REQUESTERS - 1);
	localparam level_t SLOWEST = LVL_W'(NUM_LEVELS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;

	logic [1:0] state_q;

	logic   enable_q;
	level_t highest_q;

	logic [NUM_REQUESTERS-1:0] lock_held_q;
	logic [NUM_REQUESTERS-1:0] limit_held_q;
	level_t lock_agg_q;
	level_t limit_agg_q;

	level_t lock_mem [NUM_REQUESTERS];
	level_t limit_mem [NUM_REQUESTERS];
	level_t lock_rd_s1;
	level_t limit_rd_s1;

	logic [IDX_W-1:0] cnt_q;
	logic             scan_lim_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	level_t           acc_q;

	logic   m_tvalid_q;
	level_t out_clamp_q;
	level_t out_lock_q;
	level_t out_limit_q;
	logic   out_held_q;
	logic   out_dis_q;

	// Input decode
	opcode_t          op;
	logic [REQ_W-1:0] req;
	level_t           lvl_raw;
	level_t           lvl_sat;
	level_t           hi_sat;
	logic             in_range;
	logic [IDX_W-1:0] req_idx;
	logic             accept;

	// Outcome of the current input word
	level_t res_clamp;
	level_t new_lock;
	level_t new_limit;
	logic   res_held;
	logic   res_dis;
	logic   lock_wr;
	logic   limit_wr;
	logic   lock_rel;
	logic   limit_rel;

	// Scan merge
	logic   scan_held;
	level_t scan_data;
	level_t merged;

	assign op       = s_axis_tuser;
	assign req      = s_axis_tdata[3:0];
	assign lvl_raw  = s_axis_tdata[6:4];
	assign lvl_sat  = (lvl_raw > SLOWEST) ? SLOWEST : lvl_raw;
	assign hi_sat   = (highest_q > SLOWEST) ? SLOWEST : highest_q;
	assign in_range = (32'(req) < NUM_REQUESTERS);
	assign req_idx  = IDX_W'(req);

	assign s_axis_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		res_clamp = '0;
		new_lock  = lock_agg_q;
		new_limit = limit_agg_q;
		res_held  = 1'b0;
		res_dis   = 1'b0;
		lock_wr   = 1'b0;
		limit_wr  = 1'b0;
		lock_rel  = 1'b0;
		limit_rel = 1'b0;
		case (op)
			OP_QUERY: begin
				res_clamp = lvl_sat;
				if (res_clamp > lock_agg_q)
					res_clamp = lock_agg_q;
				if (res_clamp < limit_agg_q)
					res_clamp = limit_agg_q;
			end
			OP_LOCK, OP_LOCK_REL, OP_LIMIT, OP_LIMIT_REL: begin
				if (!enable_q) begin
					res_dis = 1'b1;
				end else if (in_range) begin
					if (op == OP_LOCK) begin
						if (lock_held_q[req_idx]) begin
							res_held = 1'b1;
						end else begin
							lock_wr = 1'b1;
							if (lvl_sat < lock_agg_q)
								new_lock = lvl_sat;
						end
					end else if (op == OP_LIMIT) begin
						if (limit_held_q[req_idx]) begin
							res_held = 1'b1;
						end else begin
							limit_wr = 1'b1;
							if (lvl_sat > limit_agg_q)
								new_limit = lvl_sat;
						end
					end else if (op == OP_LOCK_REL) begin
						lock_rel = 1'b1;
					end else begin
						limit_rel = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// The held mask is stable for the whole scan, so the delayed index suffices.
	always_comb begin
		scan_held = scan_lim_q ? limit_held_q[rd_idx_s1] : lock_held_q[rd_idx_s1];
		scan_data = scan_lim_q ? limit_rd_s1 : lock_rd_s1;
		merged    = acc_q;
		if (rd_vld_s1 && scan_held) begin
			if (scan_lim_q ? (scan_data > acc_q) : (scan_data < acc_q))
				merged = scan_data;
		end
	end

	// Value memories: writes happen only while idle; the read port reads unconditionally,
	// but its data is used only while scanning, when no write can occur.
	always_ff @(posedge clk) begin
		if (accept && lock_wr)
			lock_mem[req_idx] <= lvl_sat;
		lock_rd_s1 <= lock_mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		if (accept && limit_wr)
			limit_mem[req_idx] <= lvl_sat;
		limit_rd_s1 <= limit_mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			enable_q     <= 1'b0;
			highest_q    <= 3'd2;
			lock_held_q  <= '0;
			limit_held_q <= '0;
			lock_agg_q   <= SLOWEST;
			limit_agg_q  <= '0;
			cnt_q        <= '0;
			scan_lim_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			acc_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_ENABLE:  enable_q  <= cfg_wdata[0];
					REG_HIGHEST: highest_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (state_q == ST_LAST)
				m_tvalid_q <= 1'b1;
			else if (accept && !lock_rel && !limit_rel)
				m_tvalid_q <= 1'b1;
			else if (m_axis_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						lock_agg_q  <= new_lock;
						limit_agg_q <= new_limit;
						if (lock_wr)
							lock_held_q[req_idx] <= 1'b1;
						if (limit_wr)
							limit_held_q[req_idx] <= 1'b1;
						if (lock_rel) begin
							lock_held_q[req_idx] <= 1'b0;
							acc_q      <= SLOWEST;
							scan_lim_q <= 1'b0;
							cnt_q      <= '0;
							state_q    <= ST_SCAN;
						end
						if (limit_rel) begin
							limit_held_q[req_idx] <= 1'b0;
							acc_q      <= hi_sat;
							scan_lim_q <= 1'b1;
							cnt_q      <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= 1'b1;
					acc_q     <= merged;
					if (cnt_q == LAST_IDX)
						state_q <= ST_LAST;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_LAST: begin
					// The final entry's read data arrives in this cycle.
					rd_vld_s1 <= 1'b0;
					if (scan_lim_q)
						limit_agg_q <= merged;
					else
						lock_agg_q <= merged;
					state_q <= ST_IDLE;
				end
				default: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (state_q == ST_LAST) begin
			out_clamp_q <= '0;
			out_lock_q  <= scan_lim_q ? lock_agg_q : merged;
			out_limit_q <= scan_lim_q ? merged : limit_agg_q;
			out_held_q  <= 1'b0;
			out_dis_q   <= 1'b0;
		end else if (accept && !lock_rel && !limit_rel) begin
			out_clamp_q <= res_clamp;
			out_lock_q  <= new_lock;
			out_limit_q <= new_limit;
			out_held_q  <= res_held;
			out_dis_q   <= res_dis;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {5'd0, out_dis_q, out_held_q, out_limit_q, out_lock_q, out_clamp_q};

`ifndef NO_ASSERTIONS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (state_q == ST_IDLE))
		else $error("input taken while a release scan is running");

	a_no_result_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !m_axis_tvalid)
		else $error("result word pending during a release scan");

	a_lock_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lock_agg_q <= SLOWEST) && (limit_agg_q <= SLOWEST))
		else $error("aggregate level beyond the slowest level");

	a_lock_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && (lock_held_q == '0)) |-> (lock_agg_q == SLOWEST))
		else $error("lock level not at slowest with no lock held");
`endif

endmodule
